FILE: hw/rtl/ifd_pkg.sv
`default_nettype none

package ifd_pkg;

    localparam int BYTE_W    = 8;
    localparam int CFG_IDX_W = 2;
    localparam int USER_W    = 2;
    localparam int PHASE_W   = 3;
    localparam int SEQ_SHIFT = 6;

    localparam logic [CFG_IDX_W-1:0] CFG_FLAG   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ESCAPE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_STUFF  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ADDR   = 2'd3;

    localparam logic [BYTE_W-1:0] RST_FLAG   = 8'd126;
    localparam logic [BYTE_W-1:0] RST_ESCAPE = 8'd125;
    localparam logic [BYTE_W-1:0] RST_STUFF  = 8'd32;
    localparam logic [BYTE_W-1:0] RST_ADDR   = 8'd3;

    typedef struct packed {
        logic [BYTE_W-1:0] data_byte;
        logic              is_end;
        logic              frame_ok;
        logic              reply_seq;
    } t_result;

endpackage

`default_nettype wire

FILE: hw/rtl/info_frame_deframer.sv
// Information-frame deframer with byte-stuffing removal.
// Slave stream (s_axis_*): one raw line byte per request in tdata.
// Master stream (m_axis_*): destuffed payload bytes in tdata; the end-of-frame
// request carries tlast = 1, tdata = 0 and tuser = {reply_seq, frame_ok}.
// Configuration: i_cfg_we writes i_cfg_data into register i_cfg_addr
// (0 flag, 1 escape, 2 stuff mask, 3 address); write only while idle.
// A byte taken into the input register is decoded into the output register.
// Throughput: one byte per cycle unless the master side stalls; the decode is
// a single pass through the phase, escape and check update between the input
// and output registers. Bytes that produce no result (those outside a frame,
// header, escape, the first body byte) raise no request on the master side.
// Reset: registers take their default values, the parser hunts for a flag,
// the expected sequence bit is zero and both stages are empty.
// Stall: while the master side is held, at most one more byte is taken into the
// input register, then s_axis_tready drops until the result is taken.
`default_nettype none

module info_frame_deframer (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_we,
    input  wire logic [ifd_pkg::CFG_IDX_W-1:0]  i_cfg_addr,
    input  wire logic [ifd_pkg::BYTE_W-1:0]     i_cfg_data,
    input  wire logic                           s_axis_tvalid,
    output logic                                s_axis_tready,
    input  wire logic [ifd_pkg::BYTE_W-1:0]     s_axis_tdata,  // [7:0] rx_byte
    output logic                                m_axis_tvalid,
    input  wire logic                           m_axis_tready,
    output logic [ifd_pkg::BYTE_W-1:0]          m_axis_tdata,  // [7:0] data_byte
    output logic                                m_axis_tlast,
    output logic [ifd_pkg::USER_W-1:0]          m_axis_tuser   // [0] frame_ok, [1] reply_seq
);
    import ifd_pkg::*;

    localparam logic [PHASE_W-1:0] PH_HUNT = 3'd0;
    localparam logic [PHASE_W-1:0] PH_FLAG = 3'd1;
    localparam logic [PHASE_W-1:0] PH_ADDR = 3'd2;
    localparam logic [PHASE_W-1:0] PH_CTRL = 3'd3;
    localparam logic [PHASE_W-1:0] PH_BODY = 3'd4;

    logic [BYTE_W-1:0]  r_flag, r_escape, r_stuff, r_addr;

    logic               r_in_valid;
    logic [BYTE_W-1:0]  r_in_byte;

    logic [PHASE_W-1:0] r_phase, n_phase;
    logic               r_exp_seq, n_exp_seq;
    logic               r_esc_seen, n_esc_seen;
    logic [BYTE_W-1:0]  r_check, n_check;
    logic [BYTE_W-1:0]  r_held, n_held;
    logic               r_held_valid, n_held_valid;
    logic               r_body_nz, n_body_nz;

    logic               r_out_valid;
    t_result            r_out;
    t_result            n_out;
    logic               emit;

    logic               advance;
    logic [BYTE_W-1:0]  ctrl;
    logic [BYTE_W-1:0]  d;
    logic               ok;

    assign advance       = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || advance;
    assign ctrl          = BYTE_W'(r_exp_seq) << SEQ_SHIFT;

    always_comb begin
        n_phase      = r_phase;
        n_exp_seq    = r_exp_seq;
        n_esc_seen   = r_esc_seen;
        n_check      = r_check;
        n_held       = r_held;
        n_held_valid = r_held_valid;
        n_body_nz    = r_body_nz;
        n_out        = '0;
        emit         = 1'b0;
        d            = r_in_byte;
        ok           = r_body_nz && !r_esc_seen && (r_check == '0);
        case (r_phase)
            PH_HUNT: begin
                if (r_in_byte == r_flag) begin
                    n_phase = PH_FLAG;
                end
            end
            PH_FLAG: begin
                if (r_in_byte == r_addr) begin
                    n_phase = PH_ADDR;
                end else if (r_in_byte != r_flag) begin
                    n_phase = PH_HUNT;
                end
            end
            PH_ADDR: begin
                if (r_in_byte == ctrl) begin
                    n_phase = PH_CTRL;
                end else begin
                    n_phase = (r_in_byte == r_flag) ? PH_FLAG : PH_HUNT;
                end
            end
            PH_CTRL: begin
                if (r_in_byte == (r_addr ^ ctrl)) begin
                    n_phase      = PH_BODY;
                    n_esc_seen   = 1'b0;
                    n_check      = '0;
                    n_held       = '0;
                    n_held_valid = 1'b0;
                    n_body_nz    = 1'b0;
                end else begin
                    n_phase = (r_in_byte == r_flag) ? PH_FLAG : PH_HUNT;
                end
            end
            PH_BODY: begin
                if (r_in_byte == r_flag) begin
                    emit            = 1'b1;
                    n_out.is_end    = 1'b1;
                    n_out.frame_ok  = ok;
                    n_out.reply_seq = ~r_exp_seq;
                    if (ok) begin
                        n_exp_seq = ~r_exp_seq;
                    end
                    n_phase      = PH_HUNT;
                    n_esc_seen   = 1'b0;
                    n_check      = '0;
                    n_held       = '0;
                    n_held_valid = 1'b0;
                    n_body_nz    = 1'b0;
                end else if (!r_esc_seen && (r_in_byte == r_escape)) begin
                    n_esc_seen = 1'b1;
                end else begin
                    d               = r_esc_seen ? (r_in_byte ^ r_stuff) : r_in_byte;
                    n_esc_seen      = 1'b0;
                    emit            = r_held_valid;
                    n_out.data_byte = r_held;
                    n_held          = d;
                    n_held_valid    = 1'b1;
                    n_body_nz       = 1'b1;
                    n_check         = r_check ^ d;
                end
            end
            default: begin
                n_phase = PH_HUNT;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flag   <= RST_FLAG;
            r_escape <= RST_ESCAPE;
            r_stuff  <= RST_STUFF;
            r_addr   <= RST_ADDR;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_FLAG:   r_flag   <= i_cfg_data;
                CFG_ESCAPE: r_escape <= i_cfg_data;
                CFG_STUFF:  r_stuff  <= i_cfg_data;
                CFG_ADDR:   r_addr   <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_byte <= s_axis_tdata;
        end
        if (advance) begin
            r_out <= n_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid   <= 1'b0;
            r_out_valid  <= 1'b0;
            r_phase      <= PH_HUNT;
            r_exp_seq    <= 1'b0;
            r_esc_seen   <= 1'b0;
            r_check      <= '0;
            r_held       <= '0;
            r_held_valid <= 1'b0;
            r_body_nz    <= 1'b0;
        end else begin
            if (s_axis_tready) begin
                r_in_valid <= s_axis_tvalid;
            end
            if (advance) begin
                r_out_valid  <= emit;
                r_phase      <= n_phase;
                r_exp_seq    <= n_exp_seq;
                r_esc_seen   <= n_esc_seen;
                r_check      <= n_check;
                r_held       <= n_held;
                r_held_valid <= n_held_valid;
                r_body_nz    <= n_body_nz;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out.data_byte;
    assign m_axis_tlast  = r_out.is_end;
    assign m_axis_tuser  = {r_out.reply_seq, r_out.frame_ok};

`ifndef SYNTHESIS
    a_end_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && emit && n_out.is_end) |=> (r_phase == PH_HUNT && !r_held_valid))
        else $error("end of frame did not return to hunt");

    a_end_no_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tlast) |-> (m_axis_tdata == '0))
        else $error("end-of-frame request carries data");

    a_data_no_user: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tlast) |-> (m_axis_tuser == '0))
        else $error("data request carries status");

    a_esc_in_body: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_esc_seen |-> (r_phase == PH_BODY))
        else $error("escape pending outside body");

    a_held_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_held_valid |-> r_body_nz)
        else $error("held byte without body count");

    a_seq_toggle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_exp_seq != $past(r_exp_seq)) |-> $past(advance && emit && n_out.frame_ok))
        else $error("sequence bit changed without a good frame");
`endif

endmodule

`default_nettype wire

FILE: tb/tb_info_frame_deframer.sv
`timescale 1ns / 1ps

module tb_info_frame_deframer;
    import ifd_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN_CYCLES = 4;
    localparam int PHASE_QUOTA = 125;

    localparam logic [BYTE_W-1:0] OPENING [27] = '{
        8'h00, 8'hFF,
        8'h7E, 8'h7E, 8'h03, 8'h00, 8'h03, 8'hFF, 8'h00, 8'h7D, 8'h7D, 8'hA2, 8'h7E,
        8'h7E, 8'h03, 8'h40, 8'h43, 8'h7E,
        8'h7E, 8'h03, 8'h7E, 8'h03, 8'h40, 8'h43, 8'h11, 8'h7D, 8'h7E
    };

    typedef enum logic [PHASE_W-1:0] {
        PH_HUNT,
        PH_AFTER_FLAG,
        PH_ADDR_SEEN,
        PH_CTRL_SEEN,
        PH_BODY
    } t_parse_phase;

    class deframe_scoreboard;
        logic [BYTE_W-1:0] flag_reg;
        logic [BYTE_W-1:0] escape_reg;
        logic [BYTE_W-1:0] mask_reg;
        logic [BYTE_W-1:0] addr_reg;
        t_parse_phase      phase;
        logic              seq_bit;
        logic              escape_seen;
        logic [BYTE_W-1:0] running_check;
        logic [BYTE_W-1:0] held_byte;
        logic              held_valid;
        logic              body_nonzero;
        t_result           pending_results[$];
        int                errors;
        int                data_seen;
        int                ends_seen;
        int                ends_ok;

        function new();
            flag_reg   = RST_FLAG;
            escape_reg = RST_ESCAPE;
            mask_reg   = RST_STUFF;
            addr_reg   = RST_ADDR;
            phase      = PH_HUNT;
            seq_bit    = 1'b0;
            clear_body();
            errors     = 0;
            data_seen  = 0;
            ends_seen  = 0;
            ends_ok    = 0;
        endfunction

        function void clear_body();
            escape_seen   = 1'b0;
            running_check = '0;
            held_byte     = '0;
            held_valid    = 1'b0;
            body_nonzero  = 1'b0;
        endfunction

        function void set_register(logic [CFG_IDX_W-1:0] idx, logic [BYTE_W-1:0] value);
            case (idx)
                CFG_FLAG:   flag_reg = value;
                CFG_ESCAPE: escape_reg = value;
                CFG_STUFF:  mask_reg = value;
                CFG_ADDR:   addr_reg = value;
                default: ;
            endcase
        endfunction

        function int pending_count();
            return pending_results.size();
        endfunction

        function void take_line_byte(logic [BYTE_W-1:0] c);
            logic [BYTE_W-1:0] ctrl;
            logic [BYTE_W-1:0] d;
            t_result           r;
            ctrl = 8'(seq_bit) << SEQ_SHIFT;
            case (phase)
                PH_HUNT: begin
                    if (c == flag_reg) phase = PH_AFTER_FLAG;
                end
                PH_AFTER_FLAG: begin
                    if (c == addr_reg) phase = PH_ADDR_SEEN;
                    else if (c != flag_reg) phase = PH_HUNT;
                end
                PH_ADDR_SEEN: begin
                    if (c == ctrl) phase = PH_CTRL_SEEN;
                    else phase = (c == flag_reg) ? PH_AFTER_FLAG : PH_HUNT;
                end
                PH_CTRL_SEEN: begin
                    if (c == (addr_reg ^ ctrl)) begin
                        phase = PH_BODY;
                        clear_body();
                    end else begin
                        phase = (c == flag_reg) ? PH_AFTER_FLAG : PH_HUNT;
                    end
                end
                PH_BODY: begin
                    if (c == flag_reg) begin
                        r.data_byte = '0;
                        r.is_end    = 1'b1;
                        r.frame_ok  = body_nonzero && !escape_seen && running_check == '0;
                        r.reply_seq = ~seq_bit;
                        pending_results.push_back(r);
                        if (r.frame_ok) seq_bit = ~seq_bit;
                        phase = PH_HUNT;
                        clear_body();
                        return;
                    end
                    if (escape_seen) begin
                        d = c ^ mask_reg;
                        escape_seen = 1'b0;
                    end else if (c == escape_reg) begin
                        escape_seen = 1'b1;
                        return;
                    end else begin
                        d = c;
                    end
                    if (held_valid) begin
                        r.data_byte = held_byte;
                        r.is_end    = 1'b0;
                        r.frame_ok  = 1'b0;
                        r.reply_seq = 1'b0;
                        pending_results.push_back(r);
                    end
                    held_byte     = d;
                    held_valid    = 1'b1;
                    body_nonzero  = 1'b1;
                    running_check = running_check ^ d;
                end
                default: phase = PH_HUNT;
            endcase
        endfunction

        function void check_result(logic [BYTE_W-1:0] data, logic last,
                                   logic [USER_W-1:0] user);
            t_result want;
            t_result got;
            got.data_byte = data;
            got.is_end    = last;
            got.frame_ok  = user[0];
            got.reply_seq = user[1];
            if (pending_results.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("%0t: result with nothing pending:", $realtime,
                             " data %02h end %0b ok %0b seq %0b",
                             got.data_byte, got.is_end, got.frame_ok, got.reply_seq);
                return;
            end
            want = pending_results.pop_front();
            if (want.is_end) begin
                ends_seen++;
                if (want.frame_ok) ends_ok++;
            end else begin
                data_seen++;
            end
            if (got !== want) begin
                errors++;
                if (errors <= 10)
                    $display("%0t: mismatch: expected data %02h end %0b ok %0b seq %0b",
                             $realtime, want.data_byte, want.is_end, want.frame_ok,
                             want.reply_seq,
                             ", got data %02h end %0b ok %0b seq %0b",
                             got.data_byte, got.is_end, got.frame_ok, got.reply_seq);
            end
        endfunction
    endclass

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_addr;
    logic [BYTE_W-1:0]    i_cfg_data;
    logic                 s_axis_tvalid;
    logic                 s_axis_tready;
    logic [BYTE_W-1:0]    s_axis_tdata;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready;
    logic [BYTE_W-1:0]    m_axis_tdata;
    logic                 m_axis_tlast;
    logic [USER_W-1:0]    m_axis_tuser;

    deframe_scoreboard sb = new();
    bit quiet = 1'b0;
    int sent_bytes = 0;
    int settings_used = 1;
    int cycle_count = 0;

    info_frame_deframer dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results pending",
                     cycle_count, sb.pending_count());
            $display("DONE: errors detected");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_result(m_axis_tdata, m_axis_tlast, m_axis_tuser);
    end

    initial begin : result_sink
        int stall;
        while (i_rst_n !== 1'b1) @(posedge i_clk);
        forever begin
            stall = quiet ? 0 : $urandom_range(0, 17);
            if (stall > 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!m_axis_tvalid);
        end
    end

    task automatic send_byte(input logic [BYTE_W-1:0] b);
        int gap;
        gap = quiet ? 0 : $urandom_range(0, 17);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        do @(posedge i_clk); while (!s_axis_tready);
        sb.take_line_byte(b);
        sent_bytes++;
    endtask

    // hold the sender until every pending result is out and the pipe is empty
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        while (sb.pending_count() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic put_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [BYTE_W-1:0] value);
        i_cfg_we   <= 1'b1;
        i_cfg_addr <= idx;
        i_cfg_data <= value;
        @(posedge i_clk);
        sb.set_register(idx, value);
    endtask

    task automatic apply_setting(input logic [BYTE_W-1:0] flag, input logic [BYTE_W-1:0] esc,
                                 input logic [BYTE_W-1:0] mask, input logic [BYTE_W-1:0] addr);
        drain_results();
        put_register(CFG_FLAG, flag);
        put_register(CFG_ESCAPE, esc);
        put_register(CFG_STUFF, mask);
        put_register(CFG_ADDR, addr);
        i_cfg_we <= 1'b0;
        settings_used++;
    endtask

    // nbytes counts destuffed body bytes, the last of them being the check byte
    task automatic send_frame(input int nbytes, input bit good_check, input bit dangle,
                              input int hdr_fault);
        logic [BYTE_W-1:0] raw_q[$];
        logic [BYTE_W-1:0] line_q[$];
        logic [BYTE_W-1:0] b;
        logic [BYTE_W-1:0] chk;
        logic [BYTE_W-1:0] ctrl;
        chk  = '0;
        ctrl = 8'(sb.seq_bit ^ (hdr_fault == 3)) << SEQ_SHIFT;
        for (int i = 0; i < nbytes - 1; i++) begin
            case ($urandom_range(0, 9))
                6: b = sb.flag_reg;
                7: b = sb.escape_reg;
                8: b = 8'h00;
                9: b = 8'hFF;
                default: b = 8'($urandom_range(0, 255));
            endcase
            chk ^= b;
            raw_q.push_back(b);
        end
        if (nbytes > 0)
            raw_q.push_back(good_check ? chk : chk ^ 8'($urandom_range(1, 255)));
        line_q.push_back(sb.flag_reg);
        line_q.push_back(hdr_fault == 1 ? 8'($urandom_range(0, 255)) : sb.addr_reg);
        line_q.push_back(ctrl);
        line_q.push_back(hdr_fault == 2 ? 8'($urandom_range(0, 255)) : sb.addr_reg ^ ctrl);
        foreach (raw_q[i]) begin
            if (raw_q[i] == sb.flag_reg || raw_q[i] == sb.escape_reg) begin
                line_q.push_back(sb.escape_reg);
                line_q.push_back(raw_q[i] ^ sb.mask_reg);
            end else begin
                line_q.push_back(raw_q[i]);
            end
        end
        if (dangle) line_q.push_back(sb.escape_reg);
        line_q.push_back(sb.flag_reg);
        foreach (line_q[i]) send_byte(line_q[i]);
    endtask

    task automatic run_traffic(input int quota);
        int stop_at;
        stop_at = sent_bytes + quota;
        while (sent_bytes < stop_at) begin
            quiet = ($urandom_range(0, 4) == 0);
            case ($urandom_range(0, 9))
                0: repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(0, 255)));
                1: send_frame($urandom_range(0, 13), 1'b1, 1'b0, $urandom_range(1, 3));
                2: send_frame($urandom_range(0, 2), 1'($urandom_range(0, 1)),
                              1'($urandom_range(0, 1)), 0);
                default: send_frame($urandom_range(2, 13), $urandom_range(0, 9) != 0,
                                    $urandom_range(0, 19) == 0, 0);
            endcase
            if ($urandom_range(0, 39) == 0) drain_results();
        end
    endtask

    initial begin : stimulus
        int total_errors;
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_addr    = '0;
        i_cfg_data    = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        m_axis_tready = 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (OPENING[i]) send_byte(OPENING[i]);
        drain_results();

        apply_setting(8'h00, 8'hFF, 8'hFF, 8'h00);
        run_traffic(PHASE_QUOTA);
        apply_setting(8'hFF, 8'h00, 8'h00, 8'hFF);
        run_traffic(PHASE_QUOTA);
        apply_setting(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                      8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
        run_traffic(PHASE_QUOTA);
        apply_setting(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                      8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
        run_traffic(PHASE_QUOTA);
        apply_setting(RST_FLAG, RST_ESCAPE, RST_STUFF, RST_ADDR);
        run_traffic(PHASE_QUOTA);

        drain_results();
        repeat (8) @(posedge i_clk);
        total_errors = sb.errors + sb.pending_count();
        $display("%0d line bytes sent over %0d register settings", sent_bytes, settings_used);
        $display("%0d payload bytes and %0d frame ends checked, %0d of them accepted",
                 sb.data_seen, sb.ends_seen, sb.ends_ok);
        if (total_errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("%0d mismatches", total_errors);
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
